// ===== design/joint_bilateral_filter_assert.svh =====
// Assertion macros shared by the checker.
`ifndef JOINT_BILATERAL_FILTER_ASSERT_SVH
`define JOINT_BILATERAL_FILTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JBF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define JBF_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/jbf_pkg.sv =====
// Shared types and constants of the joint bilateral filter.
`default_nettype none
package jbf_pkg;

    localparam int PIX_W      = 16;  // guide<<8 | depth
    localparam int WEIGHT_W   = 24;  // range Q0.16 times spatial 8 bit
    localparam int CNT_W      = 4;   // window cell counters
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;

    localparam logic [1:0] KIND_RANGE   = 2'd0;
    localparam logic [1:0] KIND_SPATIAL = 2'd1;
    localparam logic [1:0] KIND_PIXEL   = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW = 2'd2;

    typedef struct packed {
        logic clr_step;
        logic take;
        logic shift;
        logic issue;
        logic div_start;
        logic div_step;
        logic out_load;
    } jbf_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic in_pixel;
        logic interior;
        logic last_cell;
        logic pipe_empty;
        logic div_done;
        logic out_free;
    } jbf_status_t;

endpackage
`default_nettype wire

// ===== design/jbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;
endmodule
`default_nettype wire

// ===== design/jbf_ctrl.sv =====
// Sequencer of the joint bilateral filter: clear, load, window and divide phases.
`default_nettype none
module jbf_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    input  wire jbf_pkg::jbf_status_t status,
    output jbf_pkg::jbf_cmd_t         cmd,
    output logic                     s_tready
);
    import jbf_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_SHIFT = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (status.in_pixel) state_next = S_READ;
                end
            end
            S_READ: state_next = S_SHIFT;
            S_SHIFT: begin
                cmd.shift  = 1'b1;
                state_next = status.interior ? S_ACC : S_IDLE;
            end
            S_ACC: begin
                cmd.issue = 1'b1;
                if (status.last_cell) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (status.pipe_empty) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) state_next = S_FIN;
            end
            S_FIN: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
endmodule
`default_nettype wire

// ===== design/jbf_dp.sv =====
// Datapath: raster counters, line store, window, weighted sums, divider, output word.
`default_nettype none
module jbf_dp #(
    parameter int MAX_WINDOW = 7,
    parameter int MAX_WIDTH  = 1024
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire jbf_pkg::jbf_cmd_t                cmd,
    output jbf_pkg::jbf_status_t                  status,
    input  wire logic [jbf_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [jbf_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [jbf_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [jbf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [jbf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import jbf_pkg::*;

    localparam int WC   = MAX_WINDOW * MAX_WINDOW;
    localparam int LSR  = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int LSW  = LSR * PIX_W;
    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EWW  = $clog2(MAX_WIDTH + 1);
    localparam int CIW  = (WC > 1) ? $clog2(WC) : 1;
    localparam int HMAX = (MAX_WINDOW - 1) / 2;
    localparam int WSW  = WEIGHT_W + $clog2(WC + 1);
    localparam int DSW  = WSW + 8;

    // configuration
    logic [10:0] cfg_w_reg;
    logic [11:0] cfg_h_reg;
    logic [2:0]  cfg_ws_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg  <= 11'd640;
            cfg_h_reg  <= 12'd480;
            cfg_ws_reg <= 3'd7;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_WIDTH:  cfg_w_reg  <= cfg_wdata[10:0];
                CFG_HEIGHT: cfg_h_reg  <= cfg_wdata;
                CFG_WINDOW: cfg_ws_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    logic [EWW-1:0]   ew;
    logic [11:0]      eh;
    logic [CNT_W-1:0] half, two_h, off;

    always_comb begin
        if (32'(cfg_w_reg) > MAX_WIDTH) ew = EWW'(MAX_WIDTH);
        else if (cfg_w_reg == 11'd0)    ew = EWW'(1);
        else                            ew = EWW'(cfg_w_reg);
        eh = (cfg_h_reg == 12'd0) ? 12'd1 : cfg_h_reg;
        if (32'(cfg_ws_reg[2:1]) > HMAX) half = CNT_W'(HMAX);
        else                             half = CNT_W'(cfg_ws_reg[2:1]);
        two_h = CNT_W'({half, 1'b0});
        off   = CNT_W'(MAX_WINDOW - 1) - two_h;
    end

    // input word fields
    logic [1:0]  in_kind;
    logic [7:0]  in_tix;
    logic [15:0] in_wval;
    logic [15:0] in_pix;
    assign in_kind = s_tuser[1:0];
    assign in_tix  = s_tdata[7:0];
    assign in_wval = s_tdata[23:8];
    assign in_pix  = {s_tdata[31:24], s_tdata[39:32]};  // guide high, depth low

    // raster position: normalize the stored one, then advance
    logic [CW-1:0]  colc_reg, pc_reg;
    logic [11:0]    rowc_reg, pr_reg;
    logic [15:0]    cur_reg;
    logic [EWW-1:0] nc, ac;
    logic [12:0]    nr, ar;

    always_comb begin
        nr = s_tuser[2] ? 13'd0 : {1'b0, rowc_reg};
        nc = s_tuser[2] ? '0 : EWW'(colc_reg);
        if (nc >= ew) begin
            nc = '0;
            nr = nr + 13'd1;
        end
        if (nr >= {1'b0, eh}) nr = 13'd0;
        ac = nc + EWW'(1);
        ar = nr;
        if (ac >= ew) begin
            ac = '0;
            ar = ar + 13'd1;
        end
        if (ar >= {1'b0, eh}) ar = 13'd0;
    end

    logic take_pix;
    assign take_pix = cmd.take && (in_kind == KIND_PIXEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rowc_reg <= '0;
            colc_reg <= '0;
        end else if (take_pix) begin
            rowc_reg <= ar[11:0];
            colc_reg <= CW'(ac);
        end
    end

    always_ff @(posedge aclk) begin
        if (take_pix) begin
            pr_reg  <= nr[11:0];
            pc_reg  <= CW'(nc);
            cur_reg <= in_pix;
        end
    end

    // line store, one word per column holding the older rows
    logic [CW-1:0]  clr_cnt_reg;
    logic [LSW-1:0] ls_rdata, ls_new;
    logic [LSW+PIX_W-1:0] ls_cat;

    always_ff @(posedge aclk) begin
        if (!aresetn)          clr_cnt_reg <= '0;
        else if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + CW'(1);
    end

    assign ls_cat = {ls_rdata, cur_reg};
    assign ls_new = ls_cat[LSW-1:0];

    jbf_ram #(.WIDTH(LSW), .DEPTH(MAX_WIDTH)) u_line (
        .aclk  (aclk),
        .we    (cmd.clr_step || cmd.shift),
        .waddr (cmd.clr_step ? clr_cnt_reg : pc_reg),
        .wdata (cmd.clr_step ? '0 : ls_new),
        .raddr (pc_reg),
        .rdata (ls_rdata)
    );

    // window registers, shifted left by one column per pixel
    logic [PIX_W-1:0] win_reg [WC];
    logic [PIX_W-1:0] column [MAX_WINDOW];

    always_comb begin
        column[MAX_WINDOW-1] = cur_reg;
        for (int k = 0; k < MAX_WINDOW - 1; k++) begin
            column[MAX_WINDOW-2-k] = ls_rdata[k*PIX_W +: PIX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < WC; n++) win_reg[n] <= '0;
        end else if (cmd.shift) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                for (int j = 0; j < MAX_WINDOW - 1; j++) begin
                    win_reg[i*MAX_WINDOW+j] <= win_reg[i*MAX_WINDOW+j+1];
                end
                win_reg[i*MAX_WINDOW+MAX_WINDOW-1] <= column[i];
            end
        end
    end

    // weight tables
    logic [CIW-1:0] sidx;
    logic [7:0]     diff;
    logic [15:0]    rng_rdata;
    logic [7:0]     sp_rdata;

    jbf_ram #(.WIDTH(16), .DEPTH(256)) u_range (
        .aclk  (aclk),
        .we    (cmd.take && (in_kind == KIND_RANGE)),
        .waddr (in_tix),
        .wdata (in_wval),
        .raddr (diff),
        .rdata (rng_rdata)
    );

    jbf_ram #(.WIDTH(8), .DEPTH(WC)) u_spatial (
        .aclk  (aclk),
        .we    (cmd.take && (in_kind == KIND_SPATIAL) && (32'(in_tix) < WC)),
        .waddr (CIW'(in_tix)),
        .wdata (in_wval[7:0]),
        .raddr (sidx),
        .rdata (sp_rdata)
    );

    // cell walk: stage A picks a sample, B forms its weight, C accumulates
    logic [CNT_W-1:0] ci_reg, cj_reg;
    logic [CIW-1:0]   cell_idx, cen_idx;
    logic [PIX_W-1:0] samp, centre;
    logic             v1_reg, v2_reg;
    logic [7:0]       d1_reg, d2_reg;
    logic [WEIGHT_W-1:0]   w_reg;
    logic [WEIGHT_W+7:0]   wd_prod;
    logic [WSW-1:0]   wsum_reg;
    logic [DSW-1:0]   dsum_reg;

    always_comb begin
        cell_idx = CIW'((32'(off) + 32'(ci_reg)) * MAX_WINDOW + 32'(off) + 32'(cj_reg));
        cen_idx  = CIW'((32'(off) + 32'(half)) * (MAX_WINDOW + 1));
        sidx     = CIW'(32'(ci_reg) * MAX_WINDOW + 32'(cj_reg));
        samp     = win_reg[cell_idx];
        centre   = win_reg[cen_idx];
        diff     = (samp[15:8] > centre[15:8]) ? samp[15:8] - centre[15:8]
                                               : centre[15:8] - samp[15:8];
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            ci_reg <= '0;
            cj_reg <= '0;
        end else if (cmd.issue) begin
            if (cj_reg == two_h) begin
                cj_reg <= '0;
                ci_reg <= ci_reg + CNT_W'(1);
            end else begin
                cj_reg <= cj_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    assign wd_prod = w_reg * d2_reg;

    always_ff @(posedge aclk) begin
        d1_reg <= samp[7:0];
        d2_reg <= d1_reg;
        w_reg  <= rng_rdata * sp_rdata;
        if (cmd.shift) begin
            wsum_reg <= '0;
            dsum_reg <= '0;
        end else if (v2_reg) begin
            wsum_reg <= wsum_reg + WSW'(w_reg);
            dsum_reg <= dsum_reg + DSW'(wd_prod);
        end
    end

    // restoring divider, one quotient bit per step; the bits above the low byte decide saturation
    logic [WSW-1:0] rem_reg;
    logic [7:0]     dlo_reg, q_reg, cdep_reg;
    logic [3:0]     dcnt_reg;
    logic           zero_reg, sat_reg;
    logic [WSW:0]   trial;
    logic           fits;

    assign trial = {rem_reg, dlo_reg[7]};
    assign fits  = (trial >= {1'b0, wsum_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dcnt_reg <= ((wsum_reg == '0) || (dsum_reg[DSW-1:8] >= wsum_reg)) ? 4'd0 : 4'd8;
        end else if (cmd.div_step && (dcnt_reg != 4'd0)) begin
            dcnt_reg <= dcnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            cdep_reg <= centre[7:0];
            zero_reg <= (wsum_reg == '0);
            sat_reg  <= (dsum_reg[DSW-1:8] >= wsum_reg);
            rem_reg  <= dsum_reg[DSW-1:8];
            dlo_reg  <= dsum_reg[7:0];
            q_reg    <= '0;
        end else if (cmd.div_step && (dcnt_reg != 4'd0)) begin
            rem_reg <= fits ? WSW'(trial - {1'b0, wsum_reg}) : WSW'(trial);
            q_reg   <= {q_reg[6:0], fits};
            dlo_reg <= {dlo_reg[6:0], 1'b0};
        end
    end

    // output word
    logic             m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [7:0]       res;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic [CW-1:0]    pc_off;

    assign res    = zero_reg ? cdep_reg : (sat_reg ? 8'd255 : q_reg);
    assign orow   = pr_reg - ROW_W'(half);
    assign pc_off = pc_reg - CW'(half);
    assign ocol   = COL_W'(pc_off);

    always_ff @(posedge aclk) begin
        if (!aresetn)          m_valid_reg <= 1'b0;
        else if (cmd.out_load) m_valid_reg <= 1'b1;
        else if (m_tready)     m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_data_reg <= {2'b00, res, ocol, orow};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        status.clr_done   = (clr_cnt_reg == CW'(MAX_WIDTH - 1));
        status.in_pixel   = (in_kind == KIND_PIXEL);
        status.interior   = (pr_reg >= ROW_W'(two_h)) && (pc_reg >= CW'(two_h));
        status.last_cell  = (ci_reg == two_h) && (cj_reg == two_h);
        status.pipe_empty = !v1_reg && !v2_reg;
        status.div_done   = (dcnt_reg == 4'd0);
        status.out_free   = !m_valid_reg || m_tready;
    end
endmodule
`default_nettype wire

// ===== design/joint_bilateral_filter.sv =====
// Steps: a weight load is taken from idle; a border pixel passes read and shift;
// an interior pixel then walks (2h+1)^2 cells, h = half window (49 cells at most),
// drains, divides, outputs. One word at a time; the walk reads one range and
// one spatial weight per cycle, and the divider yields one quotient bit per cycle.
// Reset: synchronous, active-low aresetn; then a clearing pass zeroes every line store
// word with s_tready low, config writes still taken.
`default_nettype none
module joint_bilateral_filter #(
    parameter int MAX_WINDOW = 7,     // largest window side, odd
    parameter int MAX_WIDTH  = 1024   // line store depth
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // table_index[7:0], weight_value[23:8], guide_pixel[31:24], depth_pixel[39:32]
    input  wire logic [jbf_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind[1:0], frame_start[2]
    input  wire logic [jbf_pkg::S_TUSER_W-1:0]    s_tuser,
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_row[11:0], out_col[21:12], depth_out[29:22], zero pad[31:30]
    output logic      [jbf_pkg::M_TDATA_W-1:0]    m_tdata,
    // config: 0 image_width, 1 image_height, 2 window side
    input  wire logic                             cfg_we,
    input  wire logic [jbf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [jbf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import jbf_pkg::*;

    jbf_cmd_t    cmd;
    jbf_status_t status;

    // sequencer: one word in flight from take to result
    jbf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    // counters, line store, window, MAC pipe, divider and output register
    jbf_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );
endmodule
`default_nettype wire

// ===== design/jbf_checker.sv =====
// Port-level checker for the joint bilateral filter, bound to the top level.
`default_nettype none
`include "joint_bilateral_filter_assert.svh"
module jbf_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [jbf_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [jbf_pkg::M_TDATA_W-1:0] m_tdata
);
    import jbf_pkg::*;

    // stalled result holds
    `JBF_ASSERT_NXT(a_out_valid_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")
    `JBF_ASSERT_NXT(a_out_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "result word changed")
    // a taken pixel leaves the block busy, with s_tready low right after it
    `JBF_ASSERT_NXT(a_pixel_busy, s_tvalid && s_tready && (s_tuser[1:0] == KIND_PIXEL),
        !s_tready, "ready right after pixel")
    // table loads never stall the input
    `JBF_ASSERT_NXT(a_load_ready, s_tvalid && s_tready && (s_tuser[1:0] != KIND_PIXEL),
        s_tready, "stall after table load")
endmodule

bind joint_bilateral_filter jbf_checker u_jbf_checker (.*);
`default_nettype wire

// ===== tb/joint_bilateral_filter_tb.sv =====
// Self-checking testbench for joint_bilateral_filter: a stream driver, a result monitor and an in-line filter predictor.
`default_nettype none
module joint_bilateral_filter_tb;
    import jbf_pkg::*;

    localparam int MAXW       = 1024;
    localparam int WIN        = 7;
    localparam int GUIDE_MAX  = 127;    // random pixel guides stay low, so their differences stay below 128
    localparam int DRAIN      = 100;    // beyond the worst interior pixel latency
    localparam int STALL_LIMIT = 20000; // cycles with no word moving on either side
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tix;
        logic [15:0] wval;
        logic [7:0]  guide;
        logic [7:0]  depth;
        logic        fs;
    } stream_word_t;

    typedef struct packed {
        logic [11:0] row;
        logic [9:0]  col;
        logic [7:0]  depth;
    } filtered_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    joint_bilateral_filter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // table_index, weight_value, guide_pixel, depth_pixel
        .s_tuser(s_tuser),   // kind, frame_start
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata),   // out_row, out_col, depth_out
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- predictor state ----------------
    logic [15:0] ls_mem [WIN-1][MAXW];   // previous rows, newest row first
    logic [15:0] win_mem [WIN][WIN];     // sliding window, newest column at the right
    logic [15:0] range_w [256];
    logic [7:0]  spat_w [WIN*WIN];
    int unsigned row_cnt = 0, col_cnt = 0;
    int unsigned cfg_w = 640, cfg_h = 480, cfg_win = 7;

    stream_word_t word_q[$];     // words waiting to be sent
    filtered_t    filtered_q[$]; // predicted filter outputs, oldest first
    int errors = 0, n_pixels = 0, n_results = 0, n_phases = 0;
    int hold_req = 0;            // bumped to ask the receiver for a long hold-off

    initial begin
        for (int k = 0; k < WIN-1; k++)
            for (int c = 0; c < MAXW; c++) ls_mem[k][c] = '0;
        for (int i = 0; i < WIN; i++)
            for (int j = 0; j < WIN; j++) win_mem[i][j] = '0;
    end

    // Advance the predictor by one accepted word; queue the filtered pixel it yields.
    task automatic filter_pixel(input stream_word_t w);
        int unsigned ew, eh, h, r, c, off, gc, g, diff;
        logic [15:0] column [WIN];
        logic [15:0] centre, smp;
        longint unsigned wsum, dsum, wt, res;
        filtered_t f;
        if (w.kind == KIND_RANGE) begin
            range_w[w.tix] = w.wval;
            return;
        end
        if (w.kind == KIND_SPATIAL) begin
            if (w.tix < WIN*WIN) spat_w[w.tix] = w.wval[7:0];
            return;
        end
        if (w.kind != KIND_PIXEL) return;
        n_pixels++;
        ew = (cfg_w > MAXW) ? MAXW : (cfg_w < 1 ? 1 : cfg_w);
        eh = (cfg_h < 1) ? 1 : cfg_h;
        h  = cfg_win >> 1;
        if (h > (WIN-1)/2) h = (WIN-1)/2;
        r = row_cnt; c = col_cnt;
        if (w.fs) begin r = 0; c = 0; end
        if (c >= ew) begin c = 0; r++; end
        if (r >= eh) r = 0;
        column[WIN-1] = {w.guide, w.depth};
        for (int k = 0; k < WIN-1; k++) column[WIN-2-k] = ls_mem[k][c];
        for (int k = WIN-1; k > 1; k--) ls_mem[k-1][c] = ls_mem[k-2][c];
        ls_mem[0][c] = {w.guide, w.depth};
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN-1; j++) win_mem[i][j] = win_mem[i][j+1];
            win_mem[i][WIN-1] = column[i];
        end
        if (r >= 2*h && c >= 2*h) begin
            off = WIN - 1 - 2*h;
            centre = win_mem[off+h][off+h];
            gc = centre[15:8];
            wsum = 0; dsum = 0;
            for (int i = 0; i <= 2*h; i++)
                for (int j = 0; j <= 2*h; j++) begin
                    smp  = win_mem[off+i][off+j];
                    g    = smp[15:8];
                    diff = (g > gc) ? g - gc : gc - g;
                    wt   = longint'(range_w[diff]) * longint'(spat_w[i*WIN+j]);
                    wsum += wt;
                    dsum += wt * smp[7:0];
                end
            res = (wsum == 0) ? centre[7:0] : dsum / wsum;  // zero weight: pass the centre
            if (res > 255) res = 255;
            f.row = 12'(r - h); f.col = 10'(c - h); f.depth = res[7:0];
            filtered_q = {filtered_q, f};
        end
        c++;
        if (c >= ew) begin c = 0; r++; end
        if (r >= eh) r = 0;
        row_cnt = r; col_cnt = c;
    endtask

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    // ---------------- monitor, prediction and watchdog at the rising edge ----------------
    logic in_taken = 1'b0;
    int   quiet = 0;
    always @(posedge aclk) begin
        filtered_t got, want;
        in_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            filter_pixel(word_q.pop_front());
        end
        if (m_tvalid && m_tready) begin
            got = {m_tdata[11:0], m_tdata[21:12], m_tdata[29:22]};
            n_results++;
            if (filtered_q.size() == 0) begin
                report("unexpected word", int'(got), 0);
            end else begin
                want = filtered_q.pop_front();
                if (got.row != want.row) report("out_row", int'(got.row), int'(want.row));
                if (got.col != want.col) report("out_col", int'(got.col), int'(want.col));
                if (got.depth != want.depth)
                    report("depth_out", int'(got.depth), int'(want.depth));
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("joint_bilateral_filter_tb: errors");
            $finish;
        end
    end

    // ---------------- driver: bursts with random gaps ----------------
    int burst_left = 8, gap_left = 0;
    always @(negedge aclk) begin
        stream_word_t w;
        if (s_tvalid && !in_taken) begin
            // word on offer not yet taken: hold it
        end else if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (word_q.size() > 0 && aresetn) begin
            w = word_q[0];
            s_tvalid <= 1'b1;
            s_tdata  <= {w.depth, w.guide, w.wval, w.tix};
            s_tuser  <= {w.fs, w.kind};
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                // some bursts are back to back
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ---------------- receiver: stall pattern plus requested long hold ----------------
    int hold_seen = 0, hold_left = 0, mode_left = 0, mode = 0;
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 1500;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode      <= $urandom_range(0, 2);
                mode_left <= $urandom_range(5, 60);
            end else begin
                mode_left <= mode_left - 1;
            end
            // mode 0: always ready, 1: mostly ready, 2: mostly stalled
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ---------------- stimulus ----------------
    task automatic push(input logic [1:0] k, input int tix, input int wv,
                        input int g, input int d, input bit fs);
        stream_word_t w;
        w.kind = k; w.tix = tix[7:0]; w.wval = wv[15:0];
        w.guide = g[7:0]; w.depth = d[7:0]; w.fs = fs;
        word_q = {word_q, w};
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] a, input int v);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_addr <= a; cfg_wdata <= v[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (a)
            CFG_WIDTH:  cfg_w   = v & 12'h7FF;
            CFG_HEIGHT: cfg_h   = v & 12'hFFF;
            default:    cfg_win = v & 7;
        endcase
    endtask

    // all sent, all results in, then let a trailing border pixel finish
    task automatic wait_idle();
        while (word_q.size() != 0 || s_tvalid || filtered_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic set_frame(input int w, input int h, input int win);
        wait_idle();
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        cfg_write(CFG_WINDOW, win);
        n_phases++;
    endtask

    // Mostly pixels of a fresh frame; now and then weight reloads and ignored kinds.
    task automatic random_run(input int n);
        int p;
        push(KIND_PIXEL, $urandom_range(0, 255), $urandom_range(0, 65535),
             $urandom_range(0, GUIDE_MAX), $urandom_range(0, 255), 1'b1);
        for (int i = 1; i < n; i++) begin
            p = $urandom_range(0, 99);
            if (p < 85)
                push(KIND_PIXEL, $urandom_range(0, 255), $urandom_range(0, 65535),
                     $urandom_range(0, GUIDE_MAX), $urandom_range(0, 255),
                     $urandom_range(0, 29) == 0);
            else if (p < 89)
                push(KIND_RANGE, $urandom_range(0, 255), $urandom_range(0, 65535),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
            else if (p < 93)
                push(KIND_SPATIAL, ($urandom_range(0, 4) == 0) ? $urandom_range(49, 255)
                     : $urandom_range(0, 48), $urandom_range(0, 65535),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
            else
                push(KIND_NONE, $urandom_range(0, 255), $urandom_range(0, 65535),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every range entry a guide difference can reach, and every spatial entry,
        // gets a value before any pixel reads it
        for (int i = 0; i <= GUIDE_MAX; i++)
            push(KIND_RANGE, i, $urandom_range(1, 65535), 0, 0, 1'b0);
        for (int i = 0; i < WIN*WIN; i++)
            push(KIND_SPATIAL, i, $urandom_range(1, 255), 0, 0, 1'b0);

        // directed: 1x1 window, every pixel filtered
        set_frame(3, 3, 1);
        push(KIND_PIXEL, 0, 0, 0, 0, 1'b1);
        push(KIND_PIXEL, 255, 65535, 255, 255, 1'b0);
        push(KIND_PIXEL, 0, 0, 255, 0, 1'b0);
        push(KIND_PIXEL, 0, 0, 0, 255, 1'b0);
        push(KIND_SPATIAL, 0, 16'hFF00, 0, 0, 1'b0);   // low byte zero: zero weight sum
        push(KIND_PIXEL, 0, 0, 17, 201, 1'b0);        // depth passes through
        push(KIND_SPATIAL, 200, 255, 0, 0, 1'b0);     // beyond the mask: ignored
        push(KIND_PIXEL, 0, 0, 90, 33, 1'b0);
        push(KIND_SPATIAL, 0, 16'h00FF, 0, 0, 1'b0);
        push(KIND_RANGE, 0, 65535, 0, 0, 1'b0);
        push(KIND_NONE, 255, 65535, 255, 255, 1'b1);  // ignored kind, no counter move
        push(KIND_PIXEL, 0, 0, 128, 77, 1'b0);
        push(KIND_PIXEL, 0, 0, 3, 9, 1'b1);           // frame restart mid-frame
        push(KIND_RANGE, 0, $urandom_range(1, 65535), 0, 0, 1'b0);
        // directed: 3x3 window on a 3x3 frame, one interior pixel
        set_frame(3, 3, 3);
        for (int i = 0; i < 9; i++)
            push(KIND_PIXEL, 0, 0, (i == 4) ? GUIDE_MAX : 0, i * 31, i == 0);

        // random phases, extremes of each register among them
        set_frame(5, 4, 3);      random_run(20);
        set_frame(6, 6, 5);      random_run(35);
        set_frame(7, 7, 7);      random_run(55);
        set_frame(6, 5, 3);
        hold_req++;              // long receiver hold: the block must back up
        random_run(30);
        set_frame(4, 5, 2);      random_run(15);   // even window
        set_frame(0, 0, 0);      random_run(10);   // width and height clamp to 1
        set_frame(7, 3, 7);      random_run(10);   // too short for any interior row
        set_frame(2047, 4095, 6); random_run(10);  // width clamps to the store depth
        set_frame(1024, 4095, 1); random_run(10);
        set_frame(3, 7, 4);      random_run(10);
        wait_idle();

        $display("covered %0d config phases, %0d pixels, %0d filtered words checked",
                 n_phases, n_pixels, n_results);
        $display("windows 1 to 7 incl. even and zero sizes, clamped sizes, long output hold");
        if (errors == 0) begin
            $display("joint_bilateral_filter_tb: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("joint_bilateral_filter_tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
